### rtl/lcdec_pkg.sv
// ----------------------------------------------------------------------------
// lcdec_pkg
// Shared constants and tables for the two-dimensional lattice code decoder.
// ----------------------------------------------------------------------------
package lcdec_pkg;

  localparam int unsigned MODULUS_DEFAULT     = 7681;
  localparam int unsigned BETA_OFFSET_DEFAULT = 220;

  localparam int COORD_W = 13;
  localparam int MSG_W   = 4;
  localparam int NUM_CW  = 4;
  localparam int NUM_VAL = 4;

  typedef logic [1:0] cw_idx_t;

  // value index per codeword for the x and the y coordinate
  localparam cw_idx_t CW_X_SEL [NUM_CW] = '{2'd0, 2'd1, 2'd2, 2'd3};
  localparam cw_idx_t CW_Y_SEL [NUM_CW] = '{2'd0, 2'd2, 2'd1, 2'd3};

endpackage

### rtl/lcdec_dist.sv
// ----------------------------------------------------------------------------
// lcdec_dist
// Squared centered distances of both shifted coordinates to the four values.
// ----------------------------------------------------------------------------
module lcdec_dist
  import lcdec_pkg::*;
#(
  parameter int unsigned MODULUS     = MODULUS_DEFAULT,
  parameter int unsigned BETA_OFFSET = BETA_OFFSET_DEFAULT,
  parameter int          DW          = 18,
  parameter int          SQW         = 2 * DW
) (
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  output logic [SQW-1:0]     dx2 [NUM_VAL],
  output logic [SQW-1:0]     dy2 [NUM_VAL]
);

  localparam int HALF_Q  = MODULUS / 2 + 1;
  localparam int INNER_Q = MODULUS / 2;
  localparam int ALPHA   = INNER_Q / 2;
  localparam int VAL3    = BETA_OFFSET + ALPHA - INNER_Q;

  localparam logic signed [DW-1:0] HALF_S       = DW'(HALF_Q);
  localparam logic signed [DW-1:0] INNER_S      = DW'(INNER_Q);
  localparam logic signed [DW-1:0] INNER_HALF_S = DW'(INNER_Q / 2);

  localparam logic signed [DW-1:0] VAL [NUM_VAL] = '{
    DW'(0), DW'(BETA_OFFSET), DW'(ALPHA), DW'(VAL3)
  };

  function automatic logic [SQW-1:0] sq_term(input logic signed [DW-1:0] t,
                                             input logic signed [DW-1:0] v);
    logic signed [DW-1:0]  d;
    logic signed [SQW-1:0] p;
    d = t - v;
    if (d < 0) begin
      d = -d;
    end
    // single wrap by the inner modulus, may go negative
    if (d > INNER_HALF_S) begin
      d = d - INNER_S;
    end
    p = d * d;
    return p;
  endfunction

  logic signed [DW-1:0] tx;
  logic signed [DW-1:0] ty;

  assign tx = $signed({{(DW - COORD_W){1'b0}}, coord_x}) - HALF_S;
  assign ty = $signed({{(DW - COORD_W){1'b0}}, coord_y}) - HALF_S;

  always_comb begin
    for (int j = 0; j < NUM_VAL; j++) begin
      dx2[j] = sq_term(tx, VAL[j]);
      dy2[j] = sq_term(ty, VAL[j]);
    end
  end

endmodule

### rtl/lcdec_decide.sv
// ----------------------------------------------------------------------------
// lcdec_decide
// Nearest codeword selection and external flag check on the residuals.
// ----------------------------------------------------------------------------
module lcdec_decide
  import lcdec_pkg::*;
#(
  parameter int unsigned MODULUS     = MODULUS_DEFAULT,
  parameter int unsigned BETA_OFFSET = BETA_OFFSET_DEFAULT,
  parameter int          DW          = 18,
  parameter int          SQW         = 2 * DW
) (
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic [SQW-1:0]     dx2 [NUM_VAL],
  input  logic [SQW-1:0]     dy2 [NUM_VAL],
  output logic [MSG_W-1:0]   message_bits
);

  localparam int HALF_Q  = MODULUS / 2 + 1;
  localparam int INNER_Q = MODULUS / 2;
  localparam int ALPHA   = INNER_Q / 2;

  localparam logic signed [DW-1:0] ALPHA_S  = DW'(ALPHA);
  localparam logic signed [DW-1:0] BETA_S   = DW'(BETA_OFFSET);
  localparam logic signed [DW-1:0] MOD_S    = DW'(MODULUS);
  localparam logic signed [DW-1:0] MOD_HS   = DW'(MODULUS / 2);
  localparam logic signed [DW-1:0] THRESH_S = DW'(HALF_Q / 2);

  logic [SQW:0]         cw_dist [NUM_CW];
  cw_idx_t              best01;
  cw_idx_t              best23;
  cw_idx_t              best;
  logic signed [DW-1:0] cw0;
  logic signed [DW-1:0] cw1;
  logic signed [DW-1:0] rx;
  logic signed [DW-1:0] ry;
  logic signed [DW-1:0] rx_abs;
  logic signed [DW-1:0] ry_abs;

  always_comb begin
    for (int k = 0; k < NUM_CW; k++) begin
      cw_dist[k] = {1'b0, dx2[CW_X_SEL[k]]} + {1'b0, dy2[CW_Y_SEL[k]]};
    end
  end

  // compare tree, ties keep the lower index
  assign best01 = (cw_dist[1] < cw_dist[0]) ? 2'd1 : 2'd0;
  assign best23 = (cw_dist[3] < cw_dist[2]) ? 2'd3 : 2'd2;
  assign best   = (cw_dist[best23] < cw_dist[best01]) ? best23 : best01;

  assign cw0 = (best[1] ? ALPHA_S : '0) + (best[0] ? BETA_S : '0);
  assign cw1 = (best[0] ? ALPHA_S : '0) + (best[1] ? BETA_S : '0);

  always_comb begin
    rx = $signed({{(DW - COORD_W){1'b0}}, coord_x}) - cw0;
    ry = $signed({{(DW - COORD_W){1'b0}}, coord_y}) - cw1;
    if (rx > MOD_HS) begin
      rx = rx - MOD_S;
    end
    if (ry > MOD_HS) begin
      ry = ry - MOD_S;
    end
    rx_abs = (rx < 0) ? -rx : rx;
    ry_abs = (ry < 0) ? -ry : ry;
  end

  assign message_bits = {rx_abs > THRESH_S, ry_abs > THRESH_S, best};

endmodule

### rtl/two_dim_lattice_code_decoder_core.sv
// ----------------------------------------------------------------------------
// two_dim_lattice_code_decoder_core
// Decodes one coefficient pair into 4 message bits per word.
// ----------------------------------------------------------------------------
// path: the input reg loads on the accept edge, then the square reg, then the
//   result reg, which drives m_tvalid
// throughput: one word per cycle while m_tready is high, set by the three-stage
//   pipeline with per-stage ready, so bubbles are squeezed out during output stalls
// reset: rst clears the stage valid flags only; data registers are not reset
module two_dim_lattice_code_decoder_core
  import lcdec_pkg::*;
#(
  parameter int unsigned MODULUS     = MODULUS_DEFAULT,
  parameter int unsigned BETA_OFFSET = BETA_OFFSET_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // coord_x [12:0], coord_y [25:13], zero [31:26]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // message_bits [3:0], zero [7:4]
);

  localparam int DW  = $clog2(MODULUS + BETA_OFFSET + 2 ** COORD_W) + 2;
  localparam int SQW = 2 * DW;

  // stage 1: input register
  logic               v1;
  logic [COORD_W-1:0] x1;
  logic [COORD_W-1:0] y1;
  // stage 2: squared terms
  logic               v2;
  logic [COORD_W-1:0] x2;
  logic [COORD_W-1:0] y2;
  logic [SQW-1:0]     dx2 [NUM_VAL];
  logic [SQW-1:0]     dy2 [NUM_VAL];
  logic [SQW-1:0]     dx2_next [NUM_VAL];
  logic [SQW-1:0]     dy2_next [NUM_VAL];
  // stage 3: result
  logic               v3;
  logic [MSG_W-1:0]   msg;
  logic [MSG_W-1:0]   msg_next;

  logic ready1;
  logic ready2;
  logic ready3;

  assign ready3   = !v3 || m_tready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= s_tvalid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && s_tvalid) begin
      x1 <= s_tdata[COORD_W-1:0];
      y1 <= s_tdata[2*COORD_W-1:COORD_W];
    end
    if (ready2 && v1) begin
      x2  <= x1;
      y2  <= y1;
      dx2 <= dx2_next;
      dy2 <= dy2_next;
    end
    if (ready3 && v2) begin
      msg <= msg_next;
    end
  end

  lcdec_dist #(
    .MODULUS     (MODULUS),
    .BETA_OFFSET (BETA_OFFSET),
    .DW          (DW),
    .SQW         (SQW)
  ) u_dist (
    .coord_x (x1),
    .coord_y (y1),
    .dx2     (dx2_next),
    .dy2     (dy2_next)
  );

  lcdec_decide #(
    .MODULUS     (MODULUS),
    .BETA_OFFSET (BETA_OFFSET),
    .DW          (DW),
    .SQW         (SQW)
  ) u_decide (
    .coord_x      (x2),
    .coord_y      (y2),
    .dx2          (dx2),
    .dy2          (dy2),
    .message_bits (msg_next)
  );

  assign m_tvalid = v3;
  assign m_tdata  = {{(8 - MSG_W){1'b0}}, msg};

  // an empty stage anywhere must let a new word in
  a_ready_when_bubble: assert property (@(posedge clk) disable iff (rst)
    (!v1 || !v2 || !v3) |-> s_tready)
    else $error("input stalled with a free pipeline stage");

  // an accepted word always lands in the input register
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted word lost at input register");

  // a word in the square stage moves to the output when it has room
  a_s2_to_out: assert property (@(posedge clk) disable iff (rst)
    (v2 && ready3) |=> v3)
    else $error("word lost between square stage and result");

  // nothing leaves the output register without a handshake
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !m_tready) |=> (v3 && $stable(msg)))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3))
    else $error("stage valid set after reset");

endmodule

### tb/sv/tb_two_dim_lattice_code_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_dim_lattice_code_decoder_core
// Streams coefficient pairs into the lattice code decoder and checks each
// output word against an independent decoder model kept in a scoreboard.
// A directed set covers the range ends, codeword centers, ties and flag
// edges. Random pairs cluster around the codewords, with uniform noise mixed
// in. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_two_dim_lattice_code_decoder_core;
  import lcdec_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 150;

  typedef enum int {CHK_OK, CHK_MISMATCH, CHK_UNEXPECTED} chk_status_e;

  class decode_scoreboard;
    localparam int Q     = int'(MODULUS_DEFAULT);
    localparam int BETA  = int'(BETA_OFFSET_DEFAULT);
    localparam int SHIFT = Q / 2 + 1;
    localparam int INNER = Q / 2;
    localparam int ALPHA = INNER / 2;

    logic [7:0] expected_msgs[$];

    // folded squared distance; one subtraction only, may go negative
    function int fold_sq(int t, int v);
      int d;
      d = t - v;
      if (d < 0) d = -d;
      if (d > INNER / 2) d -= INNER;
      return d * d;
    endfunction

    function logic [3:0] decode_pair(int x, int y);
      int vals[4];
      int sel_y[4];
      int dx[4];
      int dy[4];
      int best_d;
      int cw_dist;
      int best;
      int cx;
      int cy;
      int rx;
      int ry;
      logic [3:0] msg;
      vals  = '{0, BETA, ALPHA, BETA + ALPHA - INNER};
      sel_y = '{0, 2, 1, 3};
      for (int j = 0; j < 4; j++) begin
        dx[j] = fold_sq(x - SHIFT, vals[j]);
        dy[j] = fold_sq(y - SHIFT, vals[j]);
      end
      best   = 0;
      best_d = dx[0] + dy[sel_y[0]];
      for (int k = 1; k < 4; k++) begin
        cw_dist = dx[k] + dy[sel_y[k]];
        if (cw_dist < best_d) begin
          best_d = cw_dist;
          best   = k;
        end
      end
      cx = ((best >> 1) & 1) * ALPHA + (best & 1) * BETA;
      cy = (best & 1) * ALPHA + ((best >> 1) & 1) * BETA;
      rx = x - cx;
      ry = y - cy;
      if (rx > Q / 2) rx -= Q;
      if (ry > Q / 2) ry -= Q;
      if (rx < 0) rx = -rx;
      if (ry < 0) ry = -ry;
      msg = 4'(best);
      msg[3] = (rx > SHIFT / 2);
      msg[2] = (ry > SHIFT / 2);
      return msg;
    endfunction

    function void note_pair(int x, int y);
      expected_msgs.push_back({4'b0, decode_pair(x, y)});
    endfunction

    function chk_status_e check_msg(logic [7:0] got, output logic [7:0] want);
      want = 'x;
      if (expected_msgs.size() == 0) return CHK_UNEXPECTED;
      want = expected_msgs.pop_front();
      return (got === want) ? CHK_OK : CHK_MISMATCH;
    endfunction

    function int pending();
      return expected_msgs.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  decode_scoreboard board = new();
  int errors         = 0;
  int cycles         = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  two_dim_lattice_code_decoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("two_dim_lattice_code_decoder_core regression: fail");
      $finish;
    end
  end

  // output side: check the accepted word, then pick next ready
  always @(posedge clk) begin
    logic [7:0] want;
    chk_status_e st;
    if (!rst && m_tvalid && m_tready) begin
      st = board.check_msg(m_tdata, want);
      if (st == CHK_UNEXPECTED)
        report_mismatch("unexpected word", m_tdata, want);
      else if (st == CHK_MISMATCH)
        report_mismatch("message_bits", m_tdata, want);
    end
    if (rst) m_tready <= 1'b0;
    else     m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task send_pair(int x, int y);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, 13'(y), 13'(x)};
    do @(posedge clk); while (!s_tready);
    board.note_pair(x, y);
  endtask

  function int near_coord(int center);
    int span;
    int v;
    case ($urandom_range(2))
      0: span = 40;
      1: span = 400;
      default: span = 1900;
    endcase
    v = center + 3841 + $urandom_range(2 * span) - span;
    v = v % 7681;
    if (v < 0) v += 7681;
    return v;
  endfunction

  task send_random(int n);
    int vals[4];
    int sel_y[4];
    int k;
    vals  = '{0, 220, 1920, -1700};
    sel_y = '{0, 2, 1, 3};
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(3);
        send_pair(near_coord(vals[k]), near_coord(vals[sel_y[k]]));
      end else if ($urandom_range(1) == 0) begin
        send_pair($urandom_range(7680), $urandom_range(7680));
      end else begin
        // full 13-bit range, including words above the modulus
        send_pair($urandom_range(8191), $urandom_range(8191));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct   = 28;
    sink_stall_pct = 76;
    send_pair(0, 0);
    send_pair(7680, 7680);
    send_pair(7681, 7681);
    send_pair(8191, 8191);
    send_pair(0, 8191);
    send_pair(8191, 0);
    // codeword centers
    send_pair(3841, 3841);
    send_pair(4061, 5761);
    send_pair(5761, 4061);
    send_pair(2141, 2141);
    // equal distance to codewords 0 and 1, then to 0 and 2, lower index wins
    send_pair(3951, 4801);
    send_pair(4801, 3951);
    // small and large residual magnitudes, on either side of the flag threshold
    send_pair(1920, 1920);
    send_pair(1921, 1921);
    send_pair(5760, 5761);
    send_pair(5761, 5760);
    // centering wraparound
    send_pair(3840, 3841);
    send_pair(3841, 3840);
    send_pair(4095, 4096);
    send_pair(5460, 1921);
    send_random(RANDOM_ITEMS);

    src_idle_pct   = 76;
    sink_stall_pct = 28;
    send_random(RANDOM_ITEMS);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_random(RANDOM_ITEMS);
    s_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("two_dim_lattice_code_decoder_core regression: pass");
    else
      $display("two_dim_lattice_code_decoder_core regression: fail");
    $finish;
  end

endmodule

### sim.f
rtl/lcdec_pkg.sv
rtl/lcdec_dist.sv
rtl/lcdec_decide.sv
rtl/two_dim_lattice_code_decoder_core.sv
tb/sv/tb_two_dim_lattice_code_decoder_core.sv
